@@ hw/rtl/fpbr_pkg.sv @@
// Shared types and codes for the framed packet byte ring.
`timescale 1ns / 1ps
package fpbr_pkg;

  typedef logic [1:0]  opcode_t;
  typedef logic [2:0]  status_t;
  typedef logic [15:0] length_t;
  typedef logic [7:0]  byte_t;

  localparam opcode_t OP_PUSH  = 2'd0;
  localparam opcode_t OP_POP   = 2'd1;
  localparam opcode_t OP_FLUSH = 2'd2;

  localparam status_t ST_OK         = 3'd0;
  localparam status_t ST_BAD_LENGTH = 3'd1;
  localparam status_t ST_OVERFLOW   = 3'd2;
  localparam status_t ST_NOT_ENOUGH = 3'd3;
  localparam status_t ST_TOO_LONG   = 3'd4;

  localparam int HEADER_BYTES = 3;

endpackage

@@ hw/rtl/fpbr_if.sv @@
// Command and response channel interfaces of the framed packet byte ring.
`timescale 1ns / 1ps
interface fpbr_cmd_if;
  import fpbr_pkg::*;
  logic    valid;
  logic    ready;
  opcode_t opcode;
  logic    chunk_start;
  length_t chunk_length;
  byte_t   data_byte;

  modport source (output valid, opcode, chunk_start, chunk_length, data_byte, input ready);
  modport sink   (input valid, opcode, chunk_start, chunk_length, data_byte, output ready);
endinterface

interface fpbr_rsp_if;
  import fpbr_pkg::*;
  logic    valid;
  logic    ready;
  status_t status;
  logic    byte_valid;
  byte_t   out_byte;
  length_t content_length;
  logic    last;

  modport source (output valid, status, byte_valid, out_byte, content_length, last,
                  input ready);
  modport sink   (input valid, status, byte_valid, out_byte, content_length, last,
                  output ready);
endinterface

@@ hw/rtl/framed_packet_byte_ring.sv @@
// Framed packet byte ring: byte ring buffer with chunked push and length-prefixed pop.
//
//   channel | dir | word
//   --------+-----+-----------------------------------------------------------
//   cmd     | in  | opcode, chunk_start, chunk_length, data_byte
//   rsp     | out | status, byte_valid, out_byte, content_length, last
//
// Push, flush and idle opcodes are handled in S_IDLE; pushes stream at one word per cycle
// while rsp is not stalled. A pop reads the header from the byte RAM in S_H1 and S_H2,
// then returns the content bytes from S_DATA, or ends at the header check, or ends in
// S_IDLE when fewer than 3 bytes are stored; no new command is taken until it is done.
// The RAM has one write and one registered read port; the read port paces the pop.
// rst is synchronous; wp, rp and chunk state clear, RAM contents do not.
// A stalled rsp holds the output register and freezes the pop sequencer in S_H2 and S_DATA.
`timescale 1ns / 1ps
module framed_packet_byte_ring #(
  parameter int DEPTH       = 4096,
  parameter int MAX_CONTENT = 64
) (
  input logic         clk,
  input logic         rst,
  fpbr_cmd_if.sink    cmd,
  fpbr_rsp_if.source  rsp
);
  import fpbr_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int UW = PW + 1;
  localparam logic [UW-1:0] DEPTH_W  = UW'(DEPTH);
  localparam logic [UW-1:0] DEPTH_M1 = UW'(DEPTH - 1);
  localparam logic [UW-1:0] HDR_W    = UW'(HEADER_BYTES);
  localparam int CW = $clog2(MAX_CONTENT + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_H1   = 2'd1;
  localparam logic [1:0] S_H2   = 2'd2;
  localparam logic [1:0] S_DATA = 2'd3;

  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] a, input logic [UW-1:0] k);
    logic [UW-1:0] s;
    s = {1'b0, a} + k;
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[PW-1:0];
  endfunction

  byte_t mem [DEPTH];
  byte_t rdata;

  logic [1:0]    state, state_next;
  logic [PW-1:0] wp, wp_next, rp, rp_next;
  logic [PW-1:0] cur, cur_next;
  logic [CW-1:0] cnt, cnt_next;
  length_t       rem, rem_next;
  logic          drop, drop_next;
  byte_t         lo, lo_next;
  length_t       clen, clen_next;

  logic    ov, ov_next;
  status_t o_status, o_status_next;
  logic    o_bv, o_bv_next;
  byte_t   o_byte, o_byte_next;
  length_t o_clen, o_clen_next;
  logic    o_last, o_last_next;

  logic          load;
  logic          we;
  logic [PW-1:0] rd_addr;
  logic [UW-1:0] used, free_sp;
  logic [PW-1:0] rp1, rp2, rp3, cur1;
  length_t       hdr_len;
  status_t       st;

  assign load      = !ov || rsp.ready;
  assign cmd.ready = (state == S_IDLE) && load;

  assign used    = (wp >= rp) ? ({1'b0, wp} - {1'b0, rp}) : ({1'b0, wp} + DEPTH_W - {1'b0, rp});
  assign free_sp = DEPTH_M1 - used;
  assign rp1     = wrap_add(rp, UW'(1));
  assign rp2     = wrap_add(rp, UW'(2));
  assign rp3     = wrap_add(rp, HDR_W);
  assign cur1    = wrap_add(cur, UW'(1));
  assign hdr_len = {rdata, lo};

  assign rsp.valid          = ov;
  assign rsp.status         = o_status;
  assign rsp.byte_valid     = o_bv;
  assign rsp.out_byte       = o_byte;
  assign rsp.content_length = o_clen;
  assign rsp.last           = o_last;

  always_comb begin
    state_next    = state;
    wp_next       = wp;
    rp_next       = rp;
    cur_next      = cur;
    cnt_next      = cnt;
    rem_next      = rem;
    drop_next     = drop;
    lo_next       = lo;
    clen_next     = clen;
    ov_next       = ov && !rsp.ready;
    o_status_next = o_status;
    o_bv_next     = o_bv;
    o_byte_next   = o_byte;
    o_clen_next   = o_clen;
    o_last_next   = o_last;
    we            = 1'b0;
    rd_addr       = rp1;
    st            = ST_OK;

    unique case (state)
      S_IDLE: begin
        if (cmd.valid && cmd.ready) begin
          if (cmd.opcode == OP_POP) begin
            if (used < HDR_W) begin
              ov_next       = 1'b1;
              o_status_next = ST_NOT_ENOUGH;
              o_bv_next     = 1'b0;
              o_byte_next   = '0;
              o_clen_next   = '0;
              o_last_next   = 1'b1;
            end else begin
              state_next = S_H1;
            end
          end else begin
            if (cmd.opcode == OP_PUSH) begin
              if (cmd.chunk_start) begin
                rem_next  = '0;
                drop_next = 1'b0;
                if (cmd.chunk_length == '0) begin
                  st = ST_BAD_LENGTH;
                end else begin
                  rem_next = cmd.chunk_length - 16'd1;
                  if (17'(cmd.chunk_length) > 17'(free_sp)) begin
                    drop_next = 1'b1;
                    st        = ST_OVERFLOW;
                  end else if (used >= DEPTH_M1) begin
                    st = ST_OVERFLOW;
                  end else begin
                    we = 1'b1;
                  end
                end
              end else if (rem == '0) begin
                st = ST_BAD_LENGTH;
              end else begin
                rem_next = rem - 16'd1;
                if (drop || used >= DEPTH_M1) begin
                  st = ST_OVERFLOW;
                end else begin
                  we = 1'b1;
                end
              end
              if (we) begin
                wp_next = wrap_add(wp, UW'(1));
              end
            end else if (cmd.opcode == OP_FLUSH) begin
              wp_next   = '0;
              rp_next   = '0;
              rem_next  = '0;
              drop_next = 1'b0;
            end
            ov_next       = 1'b1;
            o_status_next = st;
            o_bv_next     = 1'b0;
            o_byte_next   = '0;
            o_clen_next   = '0;
            o_last_next   = 1'b1;
          end
        end
      end
      S_H1: begin
        lo_next    = rdata;
        rd_addr    = rp2;
        state_next = S_H2;
      end
      S_H2: begin
        rd_addr = rp2;
        if (load) begin
          rd_addr   = rp3;
          clen_next = hdr_len;
          if (hdr_len > 16'(MAX_CONTENT)) begin
            ov_next       = 1'b1;
            o_status_next = ST_TOO_LONG;
            o_bv_next     = 1'b0;
            o_byte_next   = '0;
            o_clen_next   = hdr_len;
            o_last_next   = 1'b1;
            state_next    = S_IDLE;
          end else if (17'(used) < 17'(HDR_W) + 17'(hdr_len)) begin
            ov_next       = 1'b1;
            o_status_next = ST_NOT_ENOUGH;
            o_bv_next     = 1'b0;
            o_byte_next   = '0;
            o_clen_next   = hdr_len;
            o_last_next   = 1'b1;
            state_next    = S_IDLE;
          end else if (hdr_len == '0) begin
            ov_next       = 1'b1;
            o_status_next = ST_OK;
            o_bv_next     = 1'b0;
            o_byte_next   = '0;
            o_clen_next   = '0;
            o_last_next   = 1'b1;
            rp_next       = rp3;
            state_next    = S_IDLE;
          end else begin
            cur_next   = rp3;
            cnt_next   = '0;
            state_next = S_DATA;
          end
        end
      end
      S_DATA: begin
        rd_addr = cur;
        if (load) begin
          rd_addr       = cur1;
          cur_next      = cur1;
          cnt_next      = cnt + CW'(1);
          ov_next       = 1'b1;
          o_status_next = ST_OK;
          o_bv_next     = 1'b1;
          o_byte_next   = rdata;
          o_clen_next   = clen;
          o_last_next   = (16'(cnt) + 16'd1 == clen);
          if (16'(cnt) + 16'd1 == clen) begin
            rp_next    = cur1;
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wp] <= cmd.data_byte;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wp    <= '0;
      rp    <= '0;
      rem   <= '0;
      drop  <= 1'b0;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      wp    <= wp_next;
      rp    <= rp_next;
      rem   <= rem_next;
      drop  <= drop_next;
      ov    <= ov_next;
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    cnt      <= cnt_next;
    lo       <= lo_next;
    clen     <= clen_next;
    o_status <= o_status_next;
    o_bv     <= o_bv_next;
    o_byte   <= o_byte_next;
    o_clen   <= o_clen_next;
    o_last   <= o_last_next;
  end

endmodule
